[sv/fsprot_pkg.sv]
// fsprot_pkg: shared types and constants for the Fresnel spectral phase rotator.
// No dependencies; imported by the top level, fsprot_front and fsprot_back.
package fsprot_pkg;
	localparam int CORDIC_STEPS = 26;
	localparam int GUARD_BITS   = 4;
	localparam int GAIN_Q26     = 40752055;
	localparam int PHASE_W      = 32;

	typedef enum logic [1:0] {
		CFG_GRID_SIZE = 2'd0,
		CFG_COEF_X    = 2'd1,
		CFG_COEF_Y    = 2'd2
	} cfg_idx_t;

	typedef logic [31:0] atan_t [CORDIC_STEPS];
	localparam atan_t ATAN_TURNS = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
		32'd81, 32'd41, 32'd20
	};
endpackage

[sv/fsprot_stream_if.sv]
// fsprot_stream_if: valid/ready channel with a generic payload.
// Payload type is a parameter; no package dependency.
interface fsprot_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[sv/fresnel_spectral_phase_rotate_core.sv]
// fresnel_spectral_phase_rotate_core: top level of the spectral phase rotator.
// Uses fsprot_pkg, fsprot_stream_if, fsprot_front, fsprot_queue, fsprot_back.
//
// One bin per cycle sustained while the queue has room. The front folds
// the indices and forms the phase, the back runs a 26-stage pipelined
// CORDIC with gain and saturation. A 32-entry queue, one entry more than
// the bins the two pipelines can hold, lets input keep flowing while the
// output is stalled, until the queue and pipelines together hold 32 bins.
module fresnel_spectral_phase_rotate_core #(
	parameter int MAX_GRID = 1024,
	parameter int SAMPLE_WIDTH = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [31:0] cfg_wdata,
	fsprot_stream_if.sink   in_ch,
	fsprot_stream_if.source out_ch
);
	import fsprot_pkg::*;
	localparam int SW = SAMPLE_WIDTH;
	localparam int DEPTH = 32;
	localparam int QW = 2 * SW;

	logic [10:0] grid_q;
	logic [31:0] cx_q, cy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_q <= 11'd1024;
			cx_q <= '0;
			cy_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_GRID_SIZE: grid_q <= cfg_wdata[10:0];
				CFG_COEF_X:    cx_q <= cfg_wdata;
				CFG_COEF_Y:    cy_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// back-end output feeds the queue; the pipelines always advance and the
	// input is held off when the queue could overflow with beats in flight
	logic fr_vld, bk_vld, q_ne, q_rd, in_acc, en_b;
	logic signed [SW-1:0] fr_re, fr_im, bk_re, bk_im;
	logic [31:0] fr_ph;
	logic [QW-1:0] q_out;
	logic [$clog2(DEPTH):0] q_cnt;
	logic [6:0] infl_q;

	assign en_b = 1'b1;
	assign in_ch.ready = (7'(q_cnt) + infl_q) < 7'(DEPTH) || q_rd;
	assign in_acc = in_ch.valid && in_ch.ready;
	assign q_rd = out_ch.valid && out_ch.ready;

	// items inside front and back pipelines, not yet in queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) infl_q <= '0;
		else infl_q <= infl_q + 7'(in_acc) - 7'(bk_vld);
	end

	fsprot_front #(.MAX_GRID(MAX_GRID), .SW(SW)) u_front (
		.clk, .arst_n, .en(en_b), .in_vld(in_acc),
		.in_re(in_ch.data.sample_re), .in_im(in_ch.data.sample_im),
		.row(in_ch.data.row_index), .col(in_ch.data.col_index),
		.grid_size(grid_q), .coef_x(cx_q), .coef_y(cy_q),
		.out_vld(fr_vld), .out_re(fr_re), .out_im(fr_im), .phase(fr_ph)
	);

	fsprot_back #(.SW(SW)) u_back (
		.clk, .arst_n, .en(en_b), .in_vld(fr_vld), .in_re(fr_re), .in_im(fr_im),
		.phase(fr_ph), .out_vld(bk_vld), .out_re(bk_re), .out_im(bk_im)
	);

	fsprot_queue #(.W(QW), .DEPTH(DEPTH)) u_queue (
		.clk, .arst_n, .wr(bk_vld), .wdata({bk_re, bk_im}), .rd(q_rd),
		.rdata(q_out), .not_empty(q_ne), .count(q_cnt)
	);

	assign out_ch.valid = q_ne;
	assign out_ch.data.result_re = q_out[QW-1:SW];
	assign out_ch.data.result_im = q_out[SW-1:0];

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(bk_vld && !q_rd && q_cnt == ($clog2(DEPTH)+1)'(DEPTH))) else $error("queue overflow");
	a_read_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_rd |-> q_ne) else $error("read empty queue");
	a_budget: assert property (@(posedge clk) disable iff (!arst_n)
		(7'(q_cnt) + infl_q) <= 7'(DEPTH)) else $error("credit exceeded");
endmodule

[sv/fsprot_front.sv]
// fsprot_front: index folding and phase formation (two pipeline stages).
// Uses fsprot_pkg; feeds the CORDIC back end.
module fsprot_front #(
	parameter int MAX_GRID = 1024,
	parameter int SW = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_vld,
	input  logic signed [SW-1:0] in_re,
	input  logic signed [SW-1:0] in_im,
	input  logic [9:0]           row,
	input  logic [9:0]           col,
	input  logic [10:0]          grid_size,
	input  logic [31:0]          coef_x,
	input  logic [31:0]          coef_y,
	output logic                 out_vld,
	output logic signed [SW-1:0] out_re,
	output logic signed [SW-1:0] out_im,
	output logic [31:0]          phase
);
	import fsprot_pkg::*;
	localparam int GW = $clog2(MAX_GRID + 1);

	logic [GW-1:0] n;
	logic [GW-1:0] fx, fy;
	logic [31:0] fx2_s1, fy2_s1;
	logic signed [SW-1:0] re_s1, im_s1;
	logic vld_s1;
	logic [31:0] px, py;

	always_comb begin
		if ({21'd0, grid_size} > MAX_GRID) n = GW'(MAX_GRID);
		else n = GW'(grid_size);
	end

	function automatic logic [GW-1:0] fold(input logic [9:0] idx, input logic [GW-1:0] nn);
		logic [GW:0] i;
		i = (GW+1)'(idx);
		if (i > {1'b0, nn >> 1}) begin
			if (i < {1'b0, nn}) return GW'({1'b0, nn} - i);
			else return GW'(i - {1'b0, nn});
		end
		return GW'(i);
	endfunction

	assign fx = fold(col, n);
	assign fy = fold(row, n);
	assign px = coef_x * fx2_s1;
	assign py = coef_y * fy2_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			out_vld <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			out_vld <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fx2_s1 <= 32'(fx) * 32'(fx);
			fy2_s1 <= 32'(fy) * 32'(fy);
			re_s1 <= in_re;
			im_s1 <= in_im;
			phase <= 32'd0 - (px + py);
			out_re <= re_s1;
			out_im <= im_s1;
		end
	end
endmodule

[sv/fsprot_queue.sv]
// fsprot_queue: small FIFO of rotated results between the back end and the output.
// No package dependency.
module fsprot_queue #(
	parameter int W = 80,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr,
	input  logic [W-1:0] wdata,
	input  logic         rd,
	output logic [W-1:0] rdata,
	output logic         not_empty,
	output logic [$clog2(DEPTH):0] count
);
	localparam int AW = $clog2(DEPTH);
	logic [W-1:0] mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;

	assign not_empty = count != '0;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			count <= '0;
		end else begin
			if (wr) wp_q <= AW'((AW+1)'(wp_q) + 1'b1 == DEPTH ? 0 : wp_q + 1'b1);
			if (rd) rp_q <= AW'((AW+1)'(rp_q) + 1'b1 == DEPTH ? 0 : rp_q + 1'b1);
			count <= count + (AW+1)'(wr) - (AW+1)'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wdata;
	end
endmodule

[sv/fsprot_back.sv]
// fsprot_back: quadrant swap, 26-stage CORDIC, gain, round and saturate.
// Uses fsprot_pkg; stalls as a whole on en.
module fsprot_back #(
	parameter int SW = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_vld,
	input  logic signed [SW-1:0] in_re,
	input  logic signed [SW-1:0] in_im,
	input  logic [31:0]          phase,
	output logic                 out_vld,
	output logic signed [SW-1:0] out_re,
	output logic signed [SW-1:0] out_im
);
	import fsprot_pkg::*;
	localparam int XW = SW + GUARD_BITS + 3;
	localparam int NS = CORDIC_STEPS;
	localparam int PW = XW + 27;

	logic signed [XW-1:0] x_s [NS+1];
	logic signed [XW-1:0] y_s [NS+1];
	logic signed [33:0]   z_s [NS+1];
	logic                 v_s [NS+3];
	logic signed [PW-1:0] mx_s2, my_s2;
	logic [1:0] q;
	logic [31:0] d;
	logic signed [XW-1:0] xr, yr, xe, ye;

	function automatic logic signed [SW-1:0] sat(input logic signed [PW-1:0] p);
		logic signed [PW-1:0] r;
		r = (p + (PW'(1) <<< 29)) >>> 30;
		if (r > PW'((64'sd1 <<< (SW-1)) - 1)) return {1'b0, {(SW-1){1'b1}}};
		if (r < -PW'(64'sd1 <<< (SW-1))) return {1'b1, {(SW-1){1'b0}}};
		return SW'(r);
	endfunction

	assign q = 2'((phase + 32'h2000_0000) >> 30);
	assign d = phase - {q, 30'd0};
	assign xe = XW'(in_re);
	assign ye = XW'(in_im);

	always_comb begin
		case (q)
			2'd1: begin xr = -ye; yr = xe; end
			2'd2: begin xr = -xe; yr = -ye; end
			2'd3: begin xr = ye; yr = -xe; end
			default: begin xr = xe; yr = ye; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NS + 3; i++) v_s[i] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_vld;
			for (int i = 1; i < NS + 3; i++) v_s[i] <= v_s[i-1];
		end
	end
	assign out_vld = v_s[NS+2];

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= xr <<< GUARD_BITS;
			y_s[0] <= yr <<< GUARD_BITS;
			z_s[0] <= 34'(signed'(d));
			for (int i = 0; i < NS; i++) begin
				if (!z_s[i][33]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - 34'(ATAN_TURNS[i]);
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + 34'(ATAN_TURNS[i]);
				end
			end
			mx_s2 <= PW'(x_s[NS]) * PW'(signed'(27'(GAIN_Q26)));
			my_s2 <= PW'(y_s[NS]) * PW'(signed'(27'(GAIN_Q26)));
			out_re <= sat(mx_s2);
			out_im <= sat(my_s2);
		end
	end
endmodule

[test/testbench.sv]
// testbench: self-checking bench for fresnel_spectral_phase_rotate_core.
// Depends on fsprot_pkg and fsprot_stream_if; predicts each rotated bin
// with a bit-exact CORDIC model and checks every output beat in order.
`timescale 1ns / 1ps

module testbench;
	import fsprot_pkg::*;

	localparam int MAX_GRID = 1024;
	localparam int SW = 24;
	localparam logic [1:0] CFG_UNUSED = 2'd3;
	localparam int DRAIN_CYCLES = 40;
	localparam int STALL_LIMIT = 20000;

	typedef struct packed {
		logic signed [SW-1:0] sample_re;
		logic signed [SW-1:0] sample_im;
		logic [9:0] row_index;
		logic [9:0] col_index;
	} bin_t;

	typedef struct packed {
		logic signed [SW-1:0] result_re;
		logic signed [SW-1:0] result_im;
	} rot_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	cfg_idx_t cfg_idx;
	logic [31:0] cfg_wdata;

	fsprot_stream_if #(.payload_t(bin_t)) in_ch ();
	fsprot_stream_if #(.payload_t(rot_t)) out_ch ();

	fresnel_spectral_phase_rotate_core #(.MAX_GRID(MAX_GRID), .SAMPLE_WIDTH(SW)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	// shadow of the block's registers
	logic [10:0] grid_q;
	logic [31:0] kx_q;
	logic [31:0] ky_q;

	bin_t pending_bins[$];
	rot_t expected_bins[$];
	int errors;
	int bins_in;
	int bins_out;
	int cfg_writes;
	bit calm;          // no random idling on the input side
	bit out_calm;
	int hold_cycles;   // long receiver stall request
	int idle_cycles;

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic logic [31:0] fold_sq(logic [9:0] idx, logic [10:0] n);
		logic [31:0] f;
		f = idx;
		if (idx > n / 2)
			f = (idx < n) ? n - idx : idx - n;
		return f * f;
	endfunction

	function automatic logic signed [SW-1:0] round_sat(longint v);
		longint r;
		r = (v * GAIN_Q26 + (64'sd1 <<< 29)) >>> 30;
		if (r > (2**(SW-1)) - 1)
			r = (2**(SW-1)) - 1;
		if (r < -(2**(SW-1)))
			r = -(2**(SW-1));
		return r[SW-1:0];
	endfunction

	function automatic rot_t rotate_bin(bin_t b);
		logic [10:0] n;
		logic [31:0] phase;
		logic [31:0] d;
		logic [1:0] q;
		longint z, x, y, t, xs, ys, re, im;
		rot_t r;
		n = (grid_q > MAX_GRID) ? 11'(MAX_GRID) : grid_q;
		phase = 32'd0 - (kx_q * fold_sq(b.col_index, n) + ky_q * fold_sq(b.row_index, n));
		q = 2'((phase + 32'h2000_0000) >> 30);
		d = phase - {q, 30'd0};
		z = longint'($signed(d));
		re = b.sample_re;
		im = b.sample_im;
		case (q)
			2'd1: begin x = -im; y = re; end
			2'd2: begin x = -re; y = -im; end
			2'd3: begin x = im; y = -re; end
			default: begin x = re; y = im; end
		endcase
		x = x <<< GUARD_BITS;
		y = y <<< GUARD_BITS;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				t = x - ys; y = y + xs; x = t;
				z = z - longint'(ATAN_TURNS[i]);
			end else begin
				t = x + ys; y = y - xs; x = t;
				z = z + longint'(ATAN_TURNS[i]);
			end
		end
		r.result_re = round_sat(x);
		r.result_im = round_sat(y);
		return r;
	endfunction

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.data <= '0;
		end else if (!in_ch.valid || in_ch.ready) begin
			if (in_ch.valid) begin
				expected_bins.push_back(rotate_bin(in_ch.data));
				bins_in++;
			end
			if (pending_bins.size() > 0 && (calm || $urandom_range(99) >= 29)) begin
				in_ch.valid <= 1'b1;
				in_ch.data <= pending_bins.pop_front();
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		rot_t want;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				bins_out++;
				if (expected_bins.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected beat: re=%0d im=%0d",
							out_ch.data.result_re, out_ch.data.result_im);
				end else begin
					want = expected_bins.pop_front();
					if (out_ch.data.result_re !== want.result_re ||
						out_ch.data.result_im !== want.result_im) begin
						errors++;
						if (errors <= 10)
							$display("beat %0d mismatch: exp re=%0d im=%0d got re=%0d im=%0d",
								bins_out, want.result_re, want.result_im,
								out_ch.data.result_re, out_ch.data.result_im);
					end
				end
			end
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= out_calm || ($urandom_range(99) >= 29);
			end
		end
	end

	// watchdog on lack of progress
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("timeout: no progress for %0d cycles", STALL_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_GRID_SIZE: grid_q = val[10:0];
			CFG_COEF_X: kx_q = val;
			CFG_COEF_Y: ky_q = val;
			default: ;
		endcase
		cfg_writes++;
	endtask

	task automatic drain();
		wait (pending_bins.size() == 0 && !in_ch.valid && expected_bins.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_grid(logic [10:0] g, logic [31:0] kx, logic [31:0] ky);
		drain();
		write_reg(CFG_GRID_SIZE, {21'd0, g});
		write_reg(CFG_COEF_X, kx);
		write_reg(CFG_COEF_Y, ky);
	endtask

	function automatic bin_t any_bin();
		bin_t b;
		b.sample_re = SW'($urandom);
		b.sample_im = SW'($urandom);
		case ($urandom_range(7))
			0: b.sample_re = {1'b0, {(SW-1){1'b1}}};
			1: b.sample_im = {1'b1, {(SW-1){1'b0}}};
			default: ;
		endcase
		b.row_index = 10'($urandom);
		b.col_index = 10'($urandom);
		if ($urandom_range(3) == 0) begin
			b.row_index = 10'($urandom_range(grid_q > 2 ? (grid_q > 1023 ? 1023 : grid_q) : 3));
			b.col_index = 10'($urandom_range(grid_q > 2 ? (grid_q > 1023 ? 1023 : grid_q) : 3));
		end
		return b;
	endfunction

	function automatic bin_t mk_bin(int re, int im, int row, int col);
		bin_t b;
		b.sample_re = SW'(re);
		b.sample_im = SW'(im);
		b.row_index = 10'(row);
		b.col_index = 10'(col);
		return b;
	endfunction

	initial begin
		logic [10:0] grids[9];
		logic [31:0] kx, ky;
		int count;
		grids = '{11'd0, 11'd1, 11'd2, 11'd3, 11'd17, 11'd512, 11'd1024, 11'd1025, 11'd2047};
		errors = 0; bins_in = 0; bins_out = 0; cfg_writes = 0;
		calm = 1'b0; out_calm = 1'b0; hold_cycles = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = CFG_GRID_SIZE;
		cfg_wdata = '0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		grid_q = 11'd1024; kx_q = '0; ky_q = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: zero phase, sample extremes pass through the gain path
		pending_bins.push_back(mk_bin(8388607, 8388607, 0, 0));
		pending_bins.push_back(mk_bin(-8388608, -8388608, 1023, 1023));
		pending_bins.push_back(mk_bin(0, 0, 512, 511));
		pending_bins.push_back(mk_bin(-8388608, 8388607, 1, 2));
		// quarter-turn boundaries with fx=1, fy=0, plus one bin with fx=511, fy=1
		foreach (grids[i]) ;
		for (int k = 0; k < 6; k++) begin
			case (k)
				0: kx = 32'h4000_0000;
				1: kx = 32'h8000_0000;
				2: kx = 32'hC000_0000;
				3: kx = 32'h2000_0000;
				4: kx = 32'h1FFF_FFFF;
				default: kx = 32'hFFFF_FFFF;
			endcase
			set_grid(11'd1024, kx, 32'h0);
			pending_bins.push_back(mk_bin(8388607, 0, 0, 1));
			pending_bins.push_back(mk_bin(-8388608, 8388607, 0, 1023));
			pending_bins.push_back(mk_bin(1234567, -7654321, 1, 513));
		end
		// unused register index must leave state unchanged
		drain();
		write_reg(cfg_idx_t'(CFG_UNUSED), 32'hFFFF_FFFF);
		pending_bins.push_back(mk_bin(4000000, -4000000, 5, 3));

		// random phases over a spread of grids and coefficients
		for (int p = 0; p < 9; p++) begin
			kx = (p == 0) ? 32'h0 : (p == 8) ? 32'hFFFF_FFFF : $urandom;
			ky = (p == 1) ? 32'hFFFF_FFFF : (p == 7) ? 32'h0 : $urandom;
			set_grid(grids[p], kx, ky);
			calm = (p == 4);
			out_calm = (p == 4);
			count = (p == 6) ? 80 : 38;
			for (int i = 0; i < count; i++)
				pending_bins.push_back(any_bin());
			if (p == 6)
				hold_cycles = 300;  // fill the block and back up the input
		end
		drain();
		calm = 1'b0;
		out_calm = 1'b0;

		$display("covered %0d bins, %0d register writes, grids 0..2047, coef extremes",
			bins_in, cfg_writes);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
